>>> design/tcm_pkg.sv
//------------------------------------------------------------------------------
// Thruster command mixer package
// Axis and pair codes, calibration constants and the calibration function.
//------------------------------------------------------------------------------
`default_nettype none

package tcm_pkg;

	typedef enum logic [1:0] {
		OP_SURGE = 2'd0,
		OP_SWAY  = 2'd1,
		OP_HEAVE = 2'd2,
		OP_TURN  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		PAIR_EAST_WEST  = 2'd0,
		PAIR_NS_SWAY    = 2'd1,
		PAIR_NS_HEAVE   = 2'd2,
		PAIR_UNUSED     = 2'd3
	} pair_t;

	localparam int GAIN_W = 17;
	localparam int OFF_W  = 22;
	localparam int SUM_W  = 25;
	localparam int FRAC_W = 16;

	typedef logic [GAIN_W-1:0] gain_t;
	typedef logic [OFF_W-1:0]  offset_t;

	// Linear fits toward the south sway thruster, unsigned Q16
	localparam gain_t   GAIN_WEST   = 17'd67020;
	localparam offset_t OFF_WEST    = 22'd2684998;
	localparam gain_t   GAIN_EAST   = 17'd60823;
	localparam offset_t OFF_EAST    = 22'd1143962;
	localparam gain_t   GAIN_NSWAY  = 17'd52545;
	localparam offset_t OFF_NSWAY   = 22'd2757165;
	localparam gain_t   GAIN_SSWAY  = 17'd65536;
	localparam offset_t OFF_SSWAY   = 22'd0;
	localparam gain_t   GAIN_NHEAVE = 17'd60615;
	localparam offset_t OFF_NHEAVE  = 22'd3349270;
	localparam gain_t   GAIN_SHEAVE = 17'd58615;
	localparam offset_t OFF_SHEAVE  = 22'd944540;

	// Truncate the fraction, saturate to 255
	function automatic logic [7:0] calibrate(input logic [7:0] level, input gain_t gain,
		input offset_t offset);
		logic [SUM_W-1:0]        sum;
		logic [SUM_W-FRAC_W-1:0] y;
		sum = SUM_W'(gain) * SUM_W'(level) + SUM_W'(offset);
		y   = sum[SUM_W-1:FRAC_W];
		return y[SUM_W-FRAC_W-1] ? 8'hFF : y[7:0];
	endfunction

endpackage

`default_nettype wire

>>> design/tcm_ifs.sv
//------------------------------------------------------------------------------
// Thruster command mixer channels
// Valid/ready interfaces for the axis command and the pair drive result.
//------------------------------------------------------------------------------
`default_nettype none

interface tcm_cmd_if;
	logic             valid;
	logic             ready;
	logic [1:0]       opcode;
	logic signed [8:0] command;

	modport source (output valid, output opcode, output command, input ready);
	modport sink   (input valid, input opcode, input command, output ready);
endinterface

interface tcm_drive_if;
	logic       valid;
	logic       ready;
	logic [1:0] pair;
	logic [7:0] duty_first;
	logic       forward_first;
	logic [7:0] duty_second;
	logic       forward_second;

	modport source (output valid, output pair, output duty_first, output forward_first,
		output duty_second, output forward_second, input ready);
	modport sink   (input valid, input pair, input duty_first, input forward_first,
		input duty_second, input forward_second, output ready);
endinterface

`default_nettype wire

>>> design/thruster_command_mixer.sv
//------------------------------------------------------------------------------
// Thruster command mixer
// Maps one signed axis command onto one calibrated thruster pair.
//------------------------------------------------------------------------------
// Path: a command transaction passes the input register, then the result register
// (which captures the results of the two calibration multiplies).
// Throughput: one transaction per cycle while drive.ready is high; a stalled result stage holds off new commands.
// Reset: pipeline empty, turn steering follows the surge pair.
//------------------------------------------------------------------------------
`default_nettype none

module thruster_command_mixer (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tcm_cmd_if.sink    cmd,
	tcm_drive_if.source drive
);
	import tcm_pkg::*;

	logic              valid_s1;
	logic [1:0]        opcode_s1;
	logic [8:0]        command_s1;
	logic              lws_s1;
	logic              last_was_surge_q;

	logic              valid_s2;
	logic [1:0]        pair_s2;
	logic [7:0]        duty_first_s2;
	logic              forward_first_s2;
	logic [7:0]        duty_second_s2;
	logic              forward_second_s2;

	logic              adv_s2;
	logic              adv_s1;
	logic              cmd_take;

	logic              neg;
	logic              pos;
	logic [8:0]        mag9;
	logic [7:0]        level;
	pair_t             pair;
	logic [7:0]        duty_first;
	logic [7:0]        duty_second;
	logic              forward_first;
	logic              forward_second;

	assign adv_s2    = !valid_s2 || drive.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;
	assign cmd_take  = cmd.valid && adv_s1;

	// Input register; steering state follows each accepted surge or sway command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			last_was_surge_q <= 1'b1;
		end else begin
			if (adv_s1)
				valid_s1 <= cmd.valid;
			if (cmd_take) begin
				case (opcode_t'(cmd.opcode))
					OP_SURGE: last_was_surge_q <= 1'b1;
					OP_SWAY:  last_was_surge_q <= 1'b0;
					default:  last_was_surge_q <= last_was_surge_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			opcode_s1  <= cmd.opcode;
			command_s1 <= cmd.command;
			lws_s1     <= last_was_surge_q;
		end
	end

	// Level is 255 minus saturated magnitude; zero counts as negative
	always_comb begin
		neg   = command_s1[8];
		pos   = !neg && (command_s1 != 9'd0);
		mag9  = neg ? (~command_s1 + 9'd1) : command_s1;
		level = 8'hFF - (mag9[8] ? 8'hFF : mag9[7:0]);

		case (opcode_t'(opcode_s1))
			OP_SURGE: pair = PAIR_EAST_WEST;
			OP_SWAY:  pair = PAIR_NS_SWAY;
			OP_HEAVE: pair = PAIR_NS_HEAVE;
			OP_TURN:  pair = lws_s1 ? PAIR_EAST_WEST : PAIR_NS_SWAY;
			default:  pair = PAIR_EAST_WEST;
		endcase

		case (pair)
			PAIR_EAST_WEST: begin
				duty_first  = calibrate(level, GAIN_EAST, OFF_EAST);
				duty_second = calibrate(level, GAIN_WEST, OFF_WEST);
			end
			PAIR_NS_SWAY: begin
				duty_first  = calibrate(level, GAIN_NSWAY, OFF_NSWAY);
				duty_second = calibrate(level, GAIN_SSWAY, OFF_SSWAY);
			end
			default: begin
				duty_first  = calibrate(level, GAIN_NHEAVE, OFF_NHEAVE);
				duty_second = calibrate(level, GAIN_SHEAVE, OFF_SHEAVE);
			end
		endcase

		// Turn drives the pair in opposition; sway pair is mirrored
		if (opcode_t'(opcode_s1) == OP_TURN) begin
			forward_first  = (pair == PAIR_EAST_WEST) ? pos : !pos;
			forward_second = !forward_first;
		end else begin
			forward_first  = pos;
			forward_second = pos;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pair_s2           <= pair;
			duty_first_s2     <= duty_first;
			forward_first_s2  <= forward_first;
			duty_second_s2    <= duty_second;
			forward_second_s2 <= forward_second;
		end
	end

	assign drive.valid          = valid_s2;
	assign drive.pair           = pair_s2;
	assign drive.duty_first     = duty_first_s2;
	assign drive.forward_first  = forward_first_s2;
	assign drive.duty_second    = duty_second_s2;
	assign drive.forward_second = forward_second_s2;

endmodule

`default_nettype wire
